// File: hw/rtl/ddps_pkg.sv
package ddps_pkg;

	// fixed field widths
	localparam int SPEED_W = 16;
	localparam int GAIN_W = 16;
	localparam int PCT_W = 16;
	localparam int DUTY_W = 12;
	localparam int STEPS_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DUTY_PER_PERCENT = 40;
	localparam int DPP_W = $clog2(DUTY_PER_PERCENT + 1);
	localparam int INTEGRAL_WIDTH = 32;
	localparam int CMD_SAT_WIDTH = 48;
	localparam int OUT_SAT_WIDTH = 40;
	localparam int PCT_LIMIT = 25600;

	// datapath widths of the pi sample
	localparam int ERR_W = SPEED_W + 1;
	localparam int TERM_W = ERR_W + GAIN_W - 8;
	localparam int INT_SUM_W = (INTEGRAL_WIDTH > TERM_W ? INTEGRAL_WIDTH : TERM_W) + 1;
	localparam int CMD_W = INT_SUM_W < CMD_SAT_WIDTH ? INT_SUM_W : CMD_SAT_WIDTH;
	localparam int SCALED_W = CMD_W + GAIN_W - 12;
	localparam int OUT_W = SCALED_W < OUT_SAT_WIDTH ? SCALED_W : OUT_SAT_WIDTH;
	localparam int TURN_W = OUT_W + GAIN_W - 12;
	localparam int MIX_W = TURN_W + 2;

	// shared multiplier: wide operand taken in two halves
	localparam int MAC_A_W = CMD_W > OUT_W ? CMD_W : OUT_W;
	localparam int MAC_P_W = MAC_A_W + GAIN_W;
	localparam int MAC_LO_W = 20;
	localparam int MAC_HI_W = MAC_A_W - MAC_LO_W;
	localparam int MAC_OP_W = MAC_HI_W > MAC_LO_W + 1 ? MAC_HI_W : MAC_LO_W + 1;

	localparam logic signed [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_LIMIT);
	localparam logic signed [PCT_W-1:0] PCT_MIN = -PCT_MAX;
	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_ANG = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INT_ANG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_LIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS = 3'd6;

	localparam logic [GAIN_W-1:0] OUT_SCALE_RESET = 16'd256;
	localparam logic [STEPS_W-1:0] RAMP_STEPS_RESET = 32'h0A0C_0A07;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK = 2'd1,
		OP_DIRECT = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef struct packed {
		op_t operation;
		logic signed [SPEED_W-1:0] linear_target;
		logic signed [SPEED_W-1:0] angular_target;
		logic signed [SPEED_W-1:0] linear_measured;
		logic signed [SPEED_W-1:0] angular_measured;
		logic wheel_select;
		logic signed [PCT_W-1:0] wheel_target_value;
	} item_t;

	typedef struct packed {
		logic signed [PCT_W-1:0] right_target;
		logic signed [PCT_W-1:0] left_target;
		logic [DUTY_W-1:0] right_duty;
		logic right_forward;
		logic [DUTY_W-1:0] left_duty;
		logic left_forward;
	} result_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain_angular;
		logic [GAIN_W-1:0] integral_gain_angular;
		logic [GAIN_W-1:0] prop_gain_linear;
		logic [GAIN_W-1:0] integral_gain_linear;
		logic [GAIN_W-1:0] output_scale;
		logic [GAIN_W-1:0] half_wheel_base;
		logic [STEPS_W-1:0] ramp_steps;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic signed [MAC_A_W-1:0] a;
		logic [GAIN_W-1:0] b;
	} mac_req_t;

	typedef struct packed {
		logic done;
		logic signed [MAC_P_W-1:0] prod;
	} mac_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [ERR_W-1:0] err_lin;
		logic signed [ERR_W-1:0] err_ang;
	} pi_req_t;

	typedef struct packed {
		logic done;
		logic signed [PCT_W-1:0] right_goal;
		logic signed [PCT_W-1:0] left_goal;
	} pi_rsp_t;

	typedef struct packed {
		logic [DUTY_W-1:0] right_duty;
		logic right_forward;
		logic [DUTY_W-1:0] left_duty;
		logic left_forward;
	} wheel_st_t;

	// saturation to the full range of a signed width
	function automatic logic signed [63:0] sat_s64(input logic signed [63:0] x, input int bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	function automatic logic signed [PCT_W-1:0] clamp_pct(input logic signed [63:0] x);
		if (x > 64'(PCT_MAX)) begin
			return PCT_MAX;
		end
		if (x < 64'(PCT_MIN)) begin
			return PCT_MIN;
		end
		return PCT_W'(x);
	endfunction

endpackage

// File: hw/rtl/ddps_mac.sv
module ddps_mac import ddps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mac_req_t req,
	output mac_rsp_t rsp
);

	localparam int MUL_W = MAC_OP_W + GAIN_W + 1;

	typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mac_state_t;

	mac_state_t state_q;
	logic done_q;
	logic signed [MAC_A_W-1:0] a_q;
	logic [GAIN_W-1:0] b_q;
	logic signed [MAC_OP_W-1:0] op_a;
	logic signed [MUL_W-1:0] prod_s1;
	logic signed [MAC_P_W-1:0] acc_q;

	// low half goes in unsigned, high half carries the sign
	always_comb begin
		if (state_q == M_LO) begin
			op_a = MAC_OP_W'($signed({1'b0, a_q[MAC_LO_W-1:0]}));
		end else begin
			op_a = MAC_OP_W'($signed(a_q[MAC_A_W-1:MAC_LO_W]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_LO;
					end
				end
				M_LO: begin
					state_q <= M_HI;
				end
				M_HI: begin
					state_q <= M_SUM;
				end
				M_SUM: begin
					state_q <= M_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_s1 <= MUL_W'(op_a) * MUL_W'($signed({1'b0, b_q}));
		if (state_q == M_HI) begin
			acc_q <= MAC_P_W'(prod_s1);
		end
		if (state_q == M_SUM) begin
			acc_q <= acc_q + (MAC_P_W'(prod_s1) <<< MAC_LO_W);
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// File: hw/rtl/ddps_pi.sv
module ddps_pi import ddps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input pi_req_t req,
	output pi_rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROP,
		S_INC,
		S_CMD,
		S_SCALE,
		S_TURN,
		S_MIX
	} pi_state_t;

	pi_state_t state_q;
	logic loop_q;
	logic done_q;
	mac_req_t mac_req_q;
	mac_rsp_t mac_rsp;
	logic signed [INTEGRAL_WIDTH-1:0] integ_ang_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_lin_q;

	logic signed [ERR_W-1:0] err_ang_q;
	logic signed [ERR_W-1:0] err_lin_q;
	logic signed [TERM_W-1:0] prop_q;
	logic signed [OUT_W-1:0] out_ang_q;
	logic signed [OUT_W-1:0] out_lin_q;
	logic signed [TURN_W-1:0] turn_q;
	logic signed [PCT_W-1:0] right_q;
	logic signed [PCT_W-1:0] left_q;

	logic signed [ERR_W-1:0] err_cur;
	logic [GAIN_W-1:0] ig_cur;
	logic signed [INTEGRAL_WIDTH-1:0] integ_cur;
	logic signed [TERM_W-1:0] term;
	logic signed [INT_SUM_W-1:0] integ_sum;
	logic signed [INTEGRAL_WIDTH-1:0] integ_next;
	logic signed [INT_SUM_W-1:0] cmd_sum;
	logic signed [CMD_W-1:0] cmd_val;
	logic signed [OUT_W-1:0] scaled;
	logic signed [TURN_W-1:0] turn;
	logic signed [MIX_W-1:0] mix_sum;
	logic signed [MIX_W-1:0] mix_dif;
	logic signed [PCT_W-1:0] right_next;
	logic signed [PCT_W-1:0] left_next;

	ddps_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.req(mac_req_q),
		.rsp(mac_rsp)
	);

	// loop_q low: angular loop, high: linear loop
	assign err_cur = loop_q ? err_lin_q : err_ang_q;
	assign ig_cur = loop_q ? cfg.integral_gain_linear : cfg.integral_gain_angular;
	assign integ_cur = loop_q ? integ_lin_q : integ_ang_q;

	assign term = TERM_W'(mac_rsp.prod >>> 8);
	assign integ_sum = INT_SUM_W'(integ_cur) + INT_SUM_W'(term);
	assign integ_next = INTEGRAL_WIDTH'(sat_s64(64'(integ_sum), INTEGRAL_WIDTH));
	assign cmd_sum = INT_SUM_W'(prop_q) + INT_SUM_W'(integ_cur);
	assign cmd_val = CMD_W'(sat_s64(64'(cmd_sum), CMD_SAT_WIDTH));
	assign scaled = OUT_W'(sat_s64(64'(mac_rsp.prod >>> 12), OUT_SAT_WIDTH));
	assign turn = TURN_W'(mac_rsp.prod >>> 12);

	// right wheel is mounted mirrored
	assign mix_sum = MIX_W'(out_lin_q) + MIX_W'(turn_q);
	assign mix_dif = MIX_W'(out_lin_q) - MIX_W'(turn_q);
	assign right_next = clamp_pct(-64'(mix_sum));
	assign left_next = clamp_pct(64'(mix_dif));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loop_q <= 1'b0;
			done_q <= 1'b0;
			mac_req_q <= '0;
			integ_ang_q <= '0;
			integ_lin_q <= '0;
		end else begin
			mac_req_q.start <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						loop_q <= 1'b0;
						mac_req_q.start <= 1'b1;
						mac_req_q.a <= MAC_A_W'(req.err_ang);
						mac_req_q.b <= cfg.prop_gain_angular;
						state_q <= S_PROP;
					end
				end
				S_PROP: begin
					if (mac_rsp.done) begin
						mac_req_q.start <= 1'b1;
						mac_req_q.a <= MAC_A_W'(err_cur);
						mac_req_q.b <= ig_cur;
						state_q <= S_INC;
					end
				end
				S_INC: begin
					if (mac_rsp.done) begin
						if (loop_q) begin
							integ_lin_q <= integ_next;
						end else begin
							integ_ang_q <= integ_next;
						end
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					mac_req_q.start <= 1'b1;
					mac_req_q.a <= MAC_A_W'(cmd_val);
					mac_req_q.b <= cfg.output_scale;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (mac_rsp.done) begin
						mac_req_q.start <= 1'b1;
						if (!loop_q) begin
							loop_q <= 1'b1;
							mac_req_q.a <= MAC_A_W'(err_lin_q);
							mac_req_q.b <= cfg.prop_gain_linear;
							state_q <= S_PROP;
						end else begin
							mac_req_q.a <= MAC_A_W'(out_ang_q);
							mac_req_q.b <= cfg.half_wheel_base;
							state_q <= S_TURN;
						end
					end
				end
				S_TURN: begin
					if (mac_rsp.done) begin
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.start) begin
			err_ang_q <= req.err_ang;
			err_lin_q <= req.err_lin;
		end
		if (state_q == S_PROP && mac_rsp.done) begin
			prop_q <= term;
		end
		if (state_q == S_SCALE && mac_rsp.done) begin
			if (loop_q) begin
				out_lin_q <= scaled;
			end else begin
				out_ang_q <= scaled;
			end
		end
		if (state_q == S_TURN && mac_rsp.done) begin
			turn_q <= turn;
		end
		if (state_q == S_MIX) begin
			right_q <= right_next;
			left_q <= left_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.right_goal = right_q;
	assign rsp.left_goal = left_q;

endmodule

// File: hw/rtl/ddps_wheel.sv
module ddps_wheel import ddps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic tick,
	input logic signed [PCT_W-1:0] right_goal,
	input logic signed [PCT_W-1:0] left_goal,
	input logic [STEPS_W-1:0] ramp_steps,
	output wheel_st_t st
);

	logic signed [PCT_W-1:0] right_cmd_q;
	logic signed [PCT_W-1:0] left_cmd_q;

	// step sizes are whole percent, i.e. n * 256 in q8.8
	function automatic logic signed [PCT_W-1:0] ramp_step(
		input logic signed [PCT_W-1:0] cmd,
		input logic signed [PCT_W-1:0] goal,
		input logic [7:0] up,
		input logic [7:0] down
	);
		logic signed [PCT_W+1:0] raised;
		logic signed [PCT_W+1:0] lowered;
		raised = (PCT_W + 2)'(cmd) + $signed((PCT_W + 2)'({up, 8'h00}));
		lowered = (PCT_W + 2)'(cmd) - $signed((PCT_W + 2)'({down, 8'h00}));
		if (cmd < goal) begin
			if (raised > (PCT_W + 2)'(goal)) begin
				return goal;
			end
			return PCT_W'(raised);
		end
		if (cmd > goal) begin
			if (lowered < (PCT_W + 2)'(goal)) begin
				return goal;
			end
			return PCT_W'(lowered);
		end
		return cmd;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_of(input logic signed [PCT_W-1:0] cmd);
		logic [PCT_W-1:0] mag;
		logic [PCT_W+DPP_W-1:0] prod;
		logic [PCT_W+DPP_W-9:0] shifted;
		mag = cmd[PCT_W-1] ? PCT_W'(-cmd) : PCT_W'(cmd);
		prod = (PCT_W + DPP_W)'(mag) * (PCT_W + DPP_W)'(DUTY_PER_PERCENT);
		shifted = prod[PCT_W+DPP_W-1:8];
		if (shifted > DUTY_MAX) begin
			return DUTY_MAX;
		end
		return DUTY_W'(shifted);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_cmd_q <= '0;
			left_cmd_q <= '0;
		end else if (tick) begin
			right_cmd_q <= ramp_step(right_cmd_q, right_goal, ramp_steps[7:0], ramp_steps[15:8]);
			left_cmd_q <= ramp_step(left_cmd_q, left_goal, ramp_steps[23:16], ramp_steps[31:24]);
		end
	end

	assign st.right_duty = duty_of(right_cmd_q);
	assign st.right_forward = !right_cmd_q[PCT_W-1] && (right_cmd_q != '0);
	assign st.left_duty = duty_of(left_cmd_q);
	assign st.left_forward = !left_cmd_q[PCT_W-1] && (left_cmd_q != '0);

endmodule

// File: hw/rtl/diff_drive_pi_speed_ramp.sv
// speed controller for a two-wheel drive.
// item channel (item_valid / item_stall / item) takes one request at a time:
//   operation 0 runs both pi loops and mixes new right and left wheel targets,
//   operation 1 ramps both wheel commands one step toward their targets,
//   operation 2 loads one wheel target directly, operation 3 only reports.
// every request gives one result on the result channel: the wheel targets
// and duty / direction of both wheels as they stand after the request.
// operation 0 runs on the single shared multiplier, which works through seven
// products in turn, each in two partial products; the other operations go
// straight to the output stage. config writes (cfg_we, cfg_index, cfg_data)
// are the user's to make only while no request is open; the block has no check.
// item_stall is high from acceptance until the result sits in the output
// register; while a result waits on result_stall the next request is still
// taken, and its result holds back until that register is taken.
// reset clears the integrals, wheel targets and commands and loads the
// default gains, output scale and ramp steps.
module diff_drive_pi_speed_ramp import ddps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {T_IDLE, T_PI, T_OUT} top_state_t;

	top_state_t state_q;
	cfg_t cfg_q;
	pi_req_t pi_req_q;
	pi_rsp_t pi_rsp;
	wheel_st_t wheel_st;
	logic signed [PCT_W-1:0] right_goal_q;
	logic signed [PCT_W-1:0] left_goal_q;
	logic result_valid_q;
	result_t result_q;

	logic accept;
	logic out_free;
	logic load;
	logic tick;
	logic signed [ERR_W-1:0] err_lin;
	logic signed [ERR_W-1:0] err_ang;
	logic signed [PCT_W-1:0] direct_val;

	assign item_stall = (state_q != T_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;
	assign load = (state_q == T_OUT) && out_free;
	assign tick = accept && (item.operation == OP_TICK);

	assign err_lin = ERR_W'(item.linear_target) - ERR_W'(item.linear_measured);
	assign err_ang = ERR_W'(item.angular_target) - ERR_W'(item.angular_measured);
	assign direct_val = clamp_pct(64'(item.wheel_target_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain_angular <= '0;
			cfg_q.integral_gain_angular <= '0;
			cfg_q.prop_gain_linear <= '0;
			cfg_q.integral_gain_linear <= '0;
			cfg_q.output_scale <= OUT_SCALE_RESET;
			cfg_q.half_wheel_base <= '0;
			cfg_q.ramp_steps <= RAMP_STEPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_ANG: cfg_q.prop_gain_angular <= cfg_data[GAIN_W-1:0];
				REG_INT_ANG: cfg_q.integral_gain_angular <= cfg_data[GAIN_W-1:0];
				REG_PROP_LIN: cfg_q.prop_gain_linear <= cfg_data[GAIN_W-1:0];
				REG_INT_LIN: cfg_q.integral_gain_linear <= cfg_data[GAIN_W-1:0];
				REG_OUT_SCALE: cfg_q.output_scale <= cfg_data[GAIN_W-1:0];
				REG_HALF_BASE: cfg_q.half_wheel_base <= cfg_data[GAIN_W-1:0];
				REG_RAMP_STEPS: cfg_q.ramp_steps <= cfg_data[STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ddps_pi u_pi (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.req(pi_req_q),
		.rsp(pi_rsp)
	);

	ddps_wheel u_wheel (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.right_goal(right_goal_q),
		.left_goal(left_goal_q),
		.ramp_steps(cfg_q.ramp_steps),
		.st(wheel_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			pi_req_q <= '0;
			right_goal_q <= '0;
			left_goal_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			pi_req_q.start <= 1'b0;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						unique case (item.operation)
							OP_SAMPLE: begin
								pi_req_q.start <= 1'b1;
								pi_req_q.err_lin <= err_lin;
								pi_req_q.err_ang <= err_ang;
								state_q <= T_PI;
							end
							OP_DIRECT: begin
								if (item.wheel_select) begin
									left_goal_q <= direct_val;
								end else begin
									right_goal_q <= direct_val;
								end
								state_q <= T_OUT;
							end
							default: begin
								state_q <= T_OUT;
							end
						endcase
					end
				end
				T_PI: begin
					if (pi_rsp.done) begin
						right_goal_q <= pi_rsp.right_goal;
						left_goal_q <= pi_rsp.left_goal;
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.right_target <= right_goal_q;
			result_q.left_target <= left_goal_q;
			result_q.right_duty <= wheel_st.right_duty;
			result_q.right_forward <= wheel_st.right_forward;
			result_q.left_duty <= wheel_st.left_duty;
			result_q.left_forward <= wheel_st.left_forward;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_pi_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		pi_rsp.done |-> state_q == T_PI)
		else $error("pi sequencer finished while no control sample was open");

	a_pi_start_enters_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pi_req_q.start |-> state_q == T_PI)
		else $error("pi sequencer started outside a control sample");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == T_OUT)
		else $error("result appeared without an output load");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.right_target <= PCT_MAX) && (result.right_target >= PCT_MIN)
			&& (result.left_target <= PCT_MAX) && (result.left_target >= PCT_MIN))
		else $error("wheel target beyond 100 percent");

endmodule

// File: test/testbench.sv
module testbench import ddps_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	diff_drive_pi_speed_ramp dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// controller state as the testbench sees it
	cfg_t ctrl_regs;
	longint integ_ang;
	longint integ_lin;
	int goal_r;
	int goal_l;
	int cmd_r;
	int cmd_l;

	result_t pending_reports[$];
	result_t want;
	int fail_count;

	// sender bursts and receiver stall pattern
	int gap_pct;
	int burst_left;
	int stall_pct;
	int stall_run;
	logic stall_now;
	int stall_hold_len;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic longint limit_signed(input longint x, input int bits);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	function automatic int clamp_percent(input longint x);
		if (x > PCT_LIMIT) begin
			return PCT_LIMIT;
		end
		if (x < -PCT_LIMIT) begin
			return -PCT_LIMIT;
		end
		return int'(x);
	endfunction

	// one pi loop: returns the loop output in q8.8 percent
	function automatic longint pi_percent(input longint err, input logic [GAIN_W-1:0] pg,
			input logic [GAIN_W-1:0] ig, inout longint integ);
		longint prop;
		longint inc;
		longint cmd;
		prop = (longint'(pg) * err) >>> 8;
		inc = (longint'(ig) * err) >>> 8;
		integ = limit_signed(integ + inc, INTEGRAL_WIDTH);
		cmd = limit_signed(prop + integ, CMD_SAT_WIDTH);
		return limit_signed((cmd * longint'(ctrl_regs.output_scale)) >>> 12, OUT_SAT_WIDTH);
	endfunction

	function automatic int ramp_toward(input int cmd, input int goal, input logic [7:0] up,
			input logic [7:0] down);
		if (cmd < goal) begin
			cmd = cmd + int'(up) * 256;
			if (cmd > goal) begin
				cmd = goal;
			end
		end else if (cmd > goal) begin
			cmd = cmd - int'(down) * 256;
			if (cmd < goal) begin
				cmd = goal;
			end
		end
		return cmd;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_counts(input int cmd);
		longint mag;
		longint d;
		mag = cmd < 0 ? -longint'(cmd) : longint'(cmd);
		d = (mag * DUTY_PER_PERCENT) >>> 8;
		if (d > longint'(DUTY_MAX)) begin
			return DUTY_MAX;
		end
		return DUTY_W'(d);
	endfunction

	function automatic result_t predict_report(input item_t req);
		longint err_lin;
		longint err_ang;
		longint ang_pct;
		longint lin_pct;
		longint turn;
		int direct_pct;
		result_t rep;
		case (req.operation)
			OP_SAMPLE: begin
				err_lin = longint'($signed(req.linear_target))
					- longint'($signed(req.linear_measured));
				err_ang = longint'($signed(req.angular_target))
					- longint'($signed(req.angular_measured));
				ang_pct = pi_percent(err_ang, ctrl_regs.prop_gain_angular,
					ctrl_regs.integral_gain_angular, integ_ang);
				lin_pct = pi_percent(err_lin, ctrl_regs.prop_gain_linear,
					ctrl_regs.integral_gain_linear, integ_lin);
				turn = (ang_pct * longint'(ctrl_regs.half_wheel_base)) >>> 12;
				goal_r = clamp_percent(-(lin_pct + turn));
				goal_l = clamp_percent(lin_pct - turn);
			end
			OP_TICK: begin
				cmd_r = ramp_toward(cmd_r, goal_r, ctrl_regs.ramp_steps[7:0],
					ctrl_regs.ramp_steps[15:8]);
				cmd_l = ramp_toward(cmd_l, goal_l, ctrl_regs.ramp_steps[23:16],
					ctrl_regs.ramp_steps[31:24]);
			end
			OP_DIRECT: begin
				direct_pct = clamp_percent(longint'($signed(req.wheel_target_value)));
				if (req.wheel_select == 1'b0) begin
					goal_r = direct_pct;
				end else begin
					goal_l = direct_pct;
				end
			end
			default: begin
			end
		endcase
		rep.right_target = PCT_W'(goal_r);
		rep.left_target = PCT_W'(goal_l);
		rep.right_duty = duty_counts(cmd_r);
		rep.right_forward = cmd_r > 0;
		rep.left_duty = duty_counts(cmd_l);
		rep.left_forward = cmd_l > 0;
		return rep;
	endfunction

	function automatic item_t make_sample(input logic [15:0] lt, input logic [15:0] at,
			input logic [15:0] lm, input logic [15:0] am);
		item_t req;
		req = '0;
		req.operation = OP_SAMPLE;
		req.linear_target = lt;
		req.angular_target = at;
		req.linear_measured = lm;
		req.angular_measured = am;
		return req;
	endfunction

	function automatic item_t make_direct(input logic sel, input logic [15:0] val);
		item_t req;
		req = '0;
		req.operation = OP_DIRECT;
		req.wheel_select = sel;
		req.wheel_target_value = val;
		return req;
	endfunction

	function automatic item_t make_tick();
		item_t req;
		req = '0;
		req.operation = OP_TICK;
		return req;
	endfunction

	function automatic logic [15:0] random_speed(input int small_pct);
		if ($urandom_range(0, 99) < small_pct) begin
			return 16'($urandom_range(0, 8191) - 4096);
		end
		return 16'($urandom());
	endfunction

	function automatic item_t random_request(input int small_pct);
		item_t req;
		int pick;
		req.linear_target = random_speed(small_pct);
		req.angular_target = random_speed(small_pct);
		req.linear_measured = random_speed(small_pct);
		req.angular_measured = random_speed(small_pct);
		req.wheel_select = 1'($urandom());
		if ($urandom_range(0, 99) < 70) begin
			req.wheel_target_value = 16'($urandom_range(0, 51200) - 25600);
		end else begin
			req.wheel_target_value = 16'($urandom());
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			req.operation = OP_SAMPLE;
		end else if (pick < 75) begin
			req.operation = OP_TICK;
		end else if (pick < 95) begin
			req.operation = OP_DIRECT;
		end else begin
			req.operation = OP_NOP;
		end
		return req;
	endfunction

	// offer one request, hold it until accepted, then queue its report
	task automatic offer_request(input item_t req);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 99) < gap_pct) begin
				gap = $urandom_range(1, 8);
			end
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do begin
			@(posedge clk);
		end while (item_stall !== 1'b0);
		pending_reports.push_back(predict_report(req));
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PROP_ANG: begin
				ctrl_regs.prop_gain_angular = val[15:0];
			end
			REG_INT_ANG: begin
				ctrl_regs.integral_gain_angular = val[15:0];
			end
			REG_PROP_LIN: begin
				ctrl_regs.prop_gain_linear = val[15:0];
			end
			REG_INT_LIN: begin
				ctrl_regs.integral_gain_linear = val[15:0];
			end
			REG_OUT_SCALE: begin
				ctrl_regs.output_scale = val[15:0];
			end
			REG_HALF_BASE: begin
				ctrl_regs.half_wheel_base = val[15:0];
			end
			REG_RAMP_STEPS: begin
				ctrl_regs.ramp_steps = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_gains(input logic [15:0] pa, input logic [15:0] ia, input logic [15:0] pl,
			input logic [15:0] il, input logic [15:0] scale, input logic [15:0] base,
			input logic [31:0] steps);
		settle();
		write_reg(REG_PROP_ANG, 32'(pa));
		write_reg(REG_INT_ANG, 32'(ia));
		write_reg(REG_PROP_LIN, 32'(pl));
		write_reg(REG_INT_LIN, 32'(il));
		write_reg(REG_OUT_SCALE, 32'(scale));
		write_reg(REG_HALF_BASE, 32'(base));
		write_reg(REG_RAMP_STEPS, steps);
	endtask

	task automatic test_reset_report();
		item_t req;
		req = '1;
		req.operation = OP_NOP;
		offer_request(req);
		offer_request(make_tick());
	endtask

	task automatic test_direct_targets();
		offer_request(make_direct(1'b0, 16'sd25600));
		offer_request(make_direct(1'b1, -16'sd25600));
		// out of range values clamp to full scale
		offer_request(make_direct(1'b0, 16'h7FFF));
		offer_request(make_direct(1'b1, 16'h8000));
		repeat (5) offer_request(make_tick());
		offer_request(make_direct(1'b0, 16'h0000));
		offer_request(make_direct(1'b1, 16'h0100));
		repeat (2) offer_request(make_tick());
	endtask

	task automatic test_sample_extremes();
		// gains still at reset: targets collapse to zero
		offer_request(make_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		offer_request(make_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
		offer_request(make_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
		offer_request(make_tick());
		offer_request(make_sample(16'h1234, 16'hFEDC, 16'h1234, 16'hFEDC));
		offer_request(make_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
		offer_request(make_tick());
	endtask

	// push both integrals up toward their upper limit, then down toward their lower limit
	task automatic test_integral_windup();
		int k;
		load_gains(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0100, 16'h1000,
			RAMP_STEPS_RESET);
		gap_pct = 20;
		stall_pct = 30;
		for (k = 0; k < 140; k++) begin
			if (k % 9 == 8) begin
				offer_request(make_tick());
			end else begin
				offer_request(make_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
			end
		end
		for (k = 0; k < 280; k++) begin
			if (k % 9 == 8) begin
				offer_request(make_tick());
			end else begin
				offer_request(make_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
			end
		end
	endtask

	// receiver holds off while requests keep coming, the block must back up
	task automatic test_stalled_output();
		int k;
		settle();
		gap_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		stall_hold_len = 300;
		for (k = 0; k < 30; k++) begin
			offer_request(random_request(50));
		end
	endtask

	task automatic test_random_gains(input logic [15:0] pa, input logic [15:0] ia,
			input logic [15:0] pl, input logic [15:0] il, input logic [15:0] scale,
			input logic [15:0] base, input logic [31:0] steps, input int count, input int small_pct,
			input int gaps, input int stalls);
		int k;
		load_gains(pa, ia, pl, il, scale, base, steps);
		gap_pct = gaps;
		stall_pct = stalls;
		for (k = 0; k < count; k++) begin
			offer_request(random_request(small_pct));
		end
	endtask

	always @(negedge clk) begin
		if (stall_hold_len > 0) begin
			result_stall <= 1'b1;
			stall_hold_len = stall_hold_len - 1;
		end else begin
			if (stall_run == 0) begin
				stall_now = ($urandom_range(0, 99) < stall_pct);
				stall_run = $urandom_range(1, 6);
			end
			stall_run = stall_run - 1;
			result_stall <= stall_now;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_reports.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result rt=%0d lt=%0d", result.right_target,
						result.left_target);
				end
			end else begin
				want = pending_reports.pop_front();
				if (result.right_target !== want.right_target
						|| result.left_target !== want.left_target
						|| result.right_duty !== want.right_duty
						|| result.right_forward !== want.right_forward
						|| result.left_duty !== want.left_duty
						|| result.left_forward !== want.left_forward) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch expected rt=%0d lt=%0d rd=%0d rf=%0b ld=%0d lf=%0b",
							want.right_target, want.left_target, want.right_duty,
							want.right_forward, want.left_duty, want.left_forward);
						$display("         got      rt=%0d lt=%0d rd=%0d rf=%0b ld=%0d lf=%0b",
							result.right_target, result.left_target, result.right_duty,
							result.right_forward, result.left_duty, result.left_forward);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		gap_pct = 0;
		burst_left = 0;
		stall_pct = 0;
		stall_run = 0;
		stall_now = 1'b0;
		stall_hold_len = 0;
		ctrl_regs = '0;
		ctrl_regs.output_scale = OUT_SCALE_RESET;
		ctrl_regs.ramp_steps = RAMP_STEPS_RESET;
		integ_ang = 0;
		integ_lin = 0;
		goal_r = 0;
		goal_l = 0;
		cmd_r = 0;
		cmd_l = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_report();
		test_direct_targets();
		test_sample_extremes();
		test_integral_windup();
		test_stalled_output();
		test_random_gains(16'h0100, 16'h0010, 16'h0100, 16'h0010, 16'h0100, 16'h0800,
			RAMP_STEPS_RESET, 170, 80, 0, 0);
		test_random_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 170, 20, 40, 50);
		test_random_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			32'h0000_0000, 100, 50, 30, 30);
		test_random_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), $urandom(), 170, 50, 50, 60);
		test_random_gains(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 63)),
			16'($urandom_range(0, 1023)), 16'($urandom_range(0, 63)),
			16'($urandom_range(0, 1023)), 16'($urandom()), $urandom(), 170, 70, 20, 70);
		test_random_gains(16'($urandom()), 16'($urandom_range(0, 255)), 16'($urandom()),
			16'($urandom_range(0, 255)), 16'($urandom_range(0, 511)), 16'($urandom()),
			$urandom(), 170, 40, 60, 20);

		settle();
		repeat (60) @(posedge clk);
		if (pending_reports.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
